// File: sv/char_lcd_text_writer_unit_defines.svh
// Assertion macros for the checker file of this block.
`ifndef CHAR_LCD_TEXT_WRITER_UNIT_DEFINES_SVH
`define CHAR_LCD_TEXT_WRITER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CLTW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CLTW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/cltw_pkg.sv
// Package: command codes, constants, job and queue status types and DDRAM address function.
package cltw_pkg;

    typedef enum logic [1:0] {
        CMD_PUT     = 2'd0,
        CMD_MOVE    = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_DISPLAY = 2'd3
    } cmd_t;

    localparam int COL_W   = 6;
    localparam int LINE_W  = 3;
    localparam int CURC_W  = 7;
    localparam int ROW_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINES   = 1'd1;

    localparam logic [COL_W-1:0]  COLUMNS_RESET = 6'd16;
    localparam logic [LINE_W-1:0] LINES_RESET   = 3'd2;
    localparam logic [COL_W-1:0]  MAX_COLUMNS   = 6'd40;
    localparam logic [LINE_W-1:0] MAX_LINES     = 3'd4;

    localparam logic [7:0] NEWLINE_CODE    = 8'h0A;
    localparam logic [7:0] LCD_CLEAR       = 8'h01;
    localparam logic [7:0] LCD_RETURN_HOME = 8'h02;
    localparam logic [7:0] LCD_DISPLAY     = 8'h08;
    localparam logic [7:0] LCD_SET_ADDR    = 8'h80;
    localparam logic [7:0] ROW1_OFFSET     = 8'h40;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // One bus job: one or two bytes; the second byte is always a command byte.
    typedef struct packed {
        logic       two;
        logic       rs0;
        logic [7:0] b0;
        logic [7:0] b1;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [7:0] ddram_addr(
        input logic [CURC_W-1:0] col,
        input logic [ROW_W-1:0]  row,
        input logic [COL_W-1:0]  columns
    );
        logic [7:0] sum;
        begin
            sum = {2'b00, col[5:0]};
            if (row[0])
            begin
                sum = sum + ROW1_OFFSET;
            end
            if (row[1])
            begin
                sum = sum + {2'b00, columns};
            end
            return sum | LCD_SET_ADDR;
        end
    endfunction

endpackage

// File: sv/cltw_front.sv
// Front end: config registers, cursor tracking, command decode into bus jobs.
module cltw_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [cltw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cltw_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           accept,
    input  logic [1:0]                     command,
    input  logic [7:0]                     char_code,
    input  logic [5:0]                     target_col,
    input  logic [1:0]                     target_row,
    input  logic                           disp_enable,
    input  logic                           cursor_on,
    input  logic                           blink_on,
    output cltw_pkg::job_t                 job
);
    import cltw_pkg::*;

    logic [COL_W-1:0]  columns_reg;
    logic [LINE_W-1:0] lines_reg;
    logic [CURC_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              wrapped_reg, wrapped_next;

    cmd_t              cmd;
    logic              is_nl, skip, wrap;
    logic [CURC_W-1:0] col_inc, put_col;
    logic [2:0]        row_inc;
    logic [ROW_W-1:0]  put_row;
    logic [7:0]        put_addr, move_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= COLUMNS_RESET;
            lines_reg   <= LINES_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_COLUMNS)
            begin
                columns_reg <= (cfg_data > MAX_COLUMNS) ? MAX_COLUMNS : cfg_data;
            end
            else if (cfg_index == REG_LINES)
            begin
                lines_reg <= (cfg_data[LINE_W-1:0] > MAX_LINES) ? MAX_LINES
                                                                : cfg_data[LINE_W-1:0];
            end
        end
    end

    always_comb
    begin
        cmd     = cmd_t'(command);
        is_nl   = (char_code == NEWLINE_CODE);
        skip    = is_nl && !wrapped_reg;
        col_inc = skip ? {1'b0, columns_reg} : col_reg + 7'd1;
        wrap    = (col_inc >= {1'b0, columns_reg});
        put_col = wrap ? '0 : col_inc;
        row_inc = {1'b0, row_reg} + {2'b00, wrap};
        put_row = (row_inc >= lines_reg) ? '0 : row_inc[ROW_W-1:0];
        put_addr  = ddram_addr(put_col, put_row, columns_reg);
        move_addr = ddram_addr({1'b0, target_col}, target_row, columns_reg);

        col_next     = col_reg;
        row_next     = row_reg;
        wrapped_next = wrapped_reg;
        job          = '0;

        case (cmd)
            CMD_PUT:
            begin
                col_next     = put_col;
                row_next     = put_row;
                wrapped_next = wrap ? !is_nl : wrapped_reg;
                job.two      = !skip;
                job.rs0      = !skip;
                job.b0       = skip ? put_addr : char_code;
                job.b1       = put_addr;
            end
            CMD_MOVE:
            begin
                col_next = {1'b0, target_col};
                row_next = target_row;
                job.b0   = move_addr;
            end
            CMD_CLEAR:
            begin
                col_next = '0;
                row_next = '0;
                job.two  = 1'b1;
                job.b0   = LCD_CLEAR;
                job.b1   = LCD_RETURN_HOME;
            end
            default:
            begin
                job.b0 = LCD_DISPLAY | {5'd0, disp_enable, cursor_on, blink_on};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            wrapped_reg <= 1'b0;
        end
        else if (accept)
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            wrapped_reg <= wrapped_next;
        end
    end

endmodule

// File: sv/cltw_queue.sv
// Short job queue between the front end and the nibble sequencer.
module cltw_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  cltw_pkg::job_t      wr_job,
    input  logic                rd,
    output cltw_pkg::job_t      head,
    output cltw_pkg::q_status_t status
);
    import cltw_pkg::*;

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_wr, do_rd;

    assign status.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_wr = wr && !status.full;
    assign do_rd = rd && !status.empty;
    assign head  = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rptr_reg <= (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// File: sv/cltw_back.sv
// Back end: splits the head job into nibbles into a one-entry output register.
module cltw_back (
    input  logic           clk,
    input  logic           rst_n,
    input  cltw_pkg::job_t head,
    input  logic           head_valid,
    output logic           head_done,
    input  logic           pop,
    output logic           empty,
    output logic           register_select,
    output logic [3:0]     nibble,
    output logic           last
);
    import cltw_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic       rs_reg, last_reg;
    logic [3:0] nib_reg;
    logic       emit, is_last;
    logic [7:0] cur_byte;
    logic [1:0] final_idx;

    always_comb
    begin
        final_idx = head.two ? 2'd3 : 2'd1;
        is_last   = (idx_reg == final_idx);
        emit      = head_valid && (!out_valid_reg || pop);
        head_done = emit && is_last;
        cur_byte  = idx_reg[1] ? head.b1 : head.b0;
        idx_next  = emit ? (is_last ? 2'd0 : idx_reg + 2'd1) : idx_reg;
        out_valid_next = emit || (out_valid_reg && !pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            rs_reg   <= idx_reg[1] ? 1'b0 : head.rs0;
            nib_reg  <= idx_reg[0] ? cur_byte[3:0] : cur_byte[7:4];
            last_reg <= is_last;
        end
    end

    assign empty           = !out_valid_reg;
    assign register_select = rs_reg;
    assign nibble          = nib_reg;
    assign last            = last_reg;

endmodule

// File: sv/char_lcd_text_writer_unit.sv
// Top level: 4-bit HD44780-style character LCD command writer.
// A taken item is written into the job queue, then its nibbles into the output register.
// The sequencer sends one nibble per cycle while pop is high, so an item is 2 or 4 nibbles
// (put with data and clear: 4; newline before a wrap, move and display control: 2).
// The front takes one item per cycle until the two-entry job queue is full.
// Reset: cursor at 0,0, wrap flag clear, columns 16, lines 2, queue and output empty.
module char_lcd_text_writer_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // config write port
    input  logic                            cfg_write,
    input  logic [cltw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cltw_pkg::CFG_DATA_W-1:0] cfg_data,
    // command side
    input  logic                            push,
    output logic                            full,
    input  logic [1:0]                      command,
    input  logic [7:0]                      char_code,
    input  logic [5:0]                      target_col,
    input  logic [1:0]                      target_row,
    input  logic                            disp_enable,
    input  logic                            cursor_on,
    input  logic                            blink_on,
    // nibble side
    output logic                            empty,
    input  logic                            pop,
    output logic                            register_select,
    output logic [3:0]                      nibble,
    output logic                            last
);
    import cltw_pkg::*;

    job_t      new_job, head_job;
    q_status_t q_stat;
    logic      accept;
    logic      head_done;

    // An item is taken whenever the job queue has room; the front updates
    // the cursor in the same cycle, so back-to-back items see fresh state.
    assign full   = q_stat.full;
    assign accept = push && !q_stat.full;

    cltw_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .command     (command),
        .char_code   (char_code),
        .target_col  (target_col),
        .target_row  (target_row),
        .disp_enable (disp_enable),
        .cursor_on   (cursor_on),
        .blink_on    (blink_on),
        .job         (new_job)
    );

    // Decouples decode from the slow nibble stream.
    cltw_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (accept),
        .wr_job (new_job),
        .rd     (head_done),
        .head   (head_job),
        .status (q_stat)
    );

    // Walks the head job nibble by nibble; releases it on its final nibble.
    cltw_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head_job),
        .head_valid      (!q_stat.empty),
        .head_done       (head_done),
        .pop             (pop),
        .empty           (empty),
        .register_select (register_select),
        .nibble          (nibble),
        .last            (last)
    );

endmodule

// File: sv/cltw_checker.sv
// Port-level checker for the LCD writer, bound to the top level.
`include "char_lcd_text_writer_unit_defines.svh"

module cltw_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic       register_select,
    input logic [3:0] nibble,
    input logic       last
);

    // Waiting nibble holds until taken.
    `CLTW_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable({nibble, last}), "held item moved")

    // A data byte is always followed by an address byte.
    `CLTW_ASSERT_NOW(a_data_not_last, !empty && register_select, !last, "data nibble marked last")

    // Rest of an item streams with no gap.
    `CLTW_ASSERT_NEXT(a_no_gap, !empty && pop && !last, !empty, "gap inside an item")

    // A full queue means the output is busy next cycle.
    `CLTW_ASSERT_NEXT(a_full_busy, full, !empty, "queue full but output idle")

endmodule

bind char_lcd_text_writer_unit cltw_checker u_cltw_checker (.*);

// File: tb/sv/testbench.sv
// Self-checking testbench for char_lcd_text_writer_unit: predicts every bus nibble, checks it.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cltw_pkg::*;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  push;
    logic                  full;
    logic [1:0]            command;
    logic [7:0]            char_code;
    logic [5:0]            target_col;
    logic [1:0]            target_row;
    logic                  disp_enable;
    logic                  cursor_on;
    logic                  blink_on;
    logic                  empty;
    logic                  pop;
    logic                  register_select;
    logic [3:0]            nibble;
    logic                  last;

    // One command item as offered on the push side.
    typedef struct packed {
        cmd_t       code;
        logic [7:0] ch;
        logic [5:0] tcol;
        logic [1:0] trow;
        logic       disp;
        logic       curs;
        logic       blink;
    } lcd_cmd_t;

    // Item counts that bound the no-idle stretch on both sides.
    localparam int CALM_FROM  = 150;
    localparam int CALM_UNTIL = 230;
    // The output side freezes once this many items are in; HOLD_CYCLES sets how long.
    localparam int HOLD_AT     = 60;
    localparam int HOLD_CYCLES = 80;
    localparam int IDLE_PCT    = 8;

    // ------------------------------------------------------------------
    // Scoreboard: cursor/wrap predictor plus the queue of nibbles still owed
    // ------------------------------------------------------------------
    class lcd_nibble_scoreboard;
        typedef struct packed {
            logic       rs;
            logic [3:0] nib;
            logic       tail;
        } bus_nibble_t;

        logic [COL_W-1:0]  columns;
        logic [LINE_W-1:0] lines;
        logic [CURC_W-1:0] cur_col;
        logic [ROW_W-1:0]  cur_row;
        bit                wrapped;
        bus_nibble_t       owed_q[$];
        int                items_in;
        int                nibbles_seen;
        int                mismatches;
        int                strays;
        int                settings;
        int                per_cmd[4];

        function new();
            columns      = COLUMNS_RESET;
            lines        = LINES_RESET;
            cur_col      = '0;
            cur_row      = '0;
            wrapped      = 1'b0;
            items_in     = 0;
            nibbles_seen = 0;
            mismatches   = 0;
            strays       = 0;
            settings     = 1;
            foreach (per_cmd[i])
            begin
                per_cmd[i] = 0;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Both registers clamp; lines only looks at its low three bits.
        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            logic [LINE_W-1:0] v;
            if (idx == REG_COLUMNS)
            begin
                columns = (data > MAX_COLUMNS) ? MAX_COLUMNS : data;
            end
            else
            begin
                // lines is written last in each phase, so count geometries here
                settings++;
                v = data[LINE_W-1:0];
                lines = (v > MAX_LINES) ? MAX_LINES : v;
            end
        endfunction

        function logic [7:0] address_byte();
            int a;
            a = int'(cur_col) & 'h3F;
            if (cur_row[0])
            begin
                a += 'h40;
            end
            if (cur_row[1])
            begin
                a += int'(columns);
            end
            return a[7:0] | LCD_SET_ADDR;
        endfunction

        function void queue_byte(logic rs, logic [7:0] value, logic tail);
            owed_q.push_back('{rs: rs, nib: value[7:4], tail: 1'b0});
            owed_q.push_back('{rs: rs, nib: value[3:0], tail: tail});
        endfunction

        function void note_item(lcd_cmd_t it);
            int col;
            int row;
            items_in++;
            per_cmd[int'(it.code)]++;
            case (it.code)
                CMD_PUT:
                begin
                    col = int'(cur_col);
                    row = int'(cur_row);
                    if (it.ch == NEWLINE_CODE && !wrapped)
                    begin
                        col = int'(columns);
                    end
                    else
                    begin
                        queue_byte(1'b1, it.ch, 1'b0);
                        col++;
                    end
                    if (col >= int'(columns))
                    begin
                        col = 0;
                        row++;
                        wrapped = (it.ch != NEWLINE_CODE);
                    end
                    if (row >= int'(lines))
                    begin
                        row = 0;
                    end
                    cur_col = col[CURC_W-1:0];
                    cur_row = row[ROW_W-1:0];
                    queue_byte(1'b0, address_byte(), 1'b1);
                end
                CMD_MOVE:
                begin
                    cur_col = {1'b0, it.tcol};
                    cur_row = it.trow;
                    queue_byte(1'b0, address_byte(), 1'b1);
                end
                CMD_CLEAR:
                begin
                    queue_byte(1'b0, LCD_CLEAR, 1'b0);
                    queue_byte(1'b0, LCD_RETURN_HOME, 1'b1);
                    cur_col = '0;
                    cur_row = '0;
                end
                default:
                begin
                    queue_byte(1'b0, LCD_DISPLAY | {5'b0, it.disp, it.curs, it.blink}, 1'b1);
                end
            endcase
        endfunction

        function void check_nibble(logic rs, logic [3:0] nib, logic tail);
            bus_nibble_t want;
            nibbles_seen++;
            if (owed_q.size() == 0)
            begin
                strays++;
                if (mismatches + strays <= 10)
                begin
                    $display("[%0t] nibble with nothing owed: rs=%0d nibble=%h last=%0d",
                             $realtime, rs, nib, tail);
                end
                return;
            end
            want = owed_q.pop_front();
            if (want.rs !== rs || want.nib !== nib || want.tail !== tail)
            begin
                mismatches++;
                if (mismatches + strays <= 10)
                begin
                    $display("[%0t] nibble %0d: expected rs=%0d nibble=%h last=%0d,",
                             $realtime, nibbles_seen, want.rs, want.nib, want.tail);
                    $display("    got rs=%0d nibble=%h last=%0d", rs, nib, tail);
                end
            end
        endfunction
    endclass

    lcd_nibble_scoreboard sb = new();

    // ------------------------------------------------------------------
    // DUT
    // ------------------------------------------------------------------
    char_lcd_text_writer_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .push            (push),
        .full            (full),
        .command         (command),
        .char_code       (char_code),
        .target_col      (target_col),
        .target_row      (target_row),
        .disp_enable     (disp_enable),
        .cursor_on       (cursor_on),
        .blink_on        (blink_on),
        .empty           (empty),
        .pop             (pop),
        .register_select (register_select),
        .nibble          (nibble),
        .last            (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop; the slowest legal run is a small fraction of this.
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic bit in_calm_stretch();
        return sb.items_in >= CALM_FROM && sb.items_in < CALM_UNTIL;
    endfunction

    // ------------------------------------------------------------------
    // Output side: pop driven on the falling edge, nibbles checked on the rising edge.
    // Random stalls, one long freeze so the job queue backs up and full rises,
    // and a calm stretch with pop held high.
    // ------------------------------------------------------------------
    initial
    begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        pop       = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && sb.items_in >= HOLD_AT)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop = 1'b0;
            end
            else if (in_calm_stretch())
            begin
                pop = 1'b1;
            end
            else
            begin
                pop = ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            sb.check_nibble(register_select, nibble, last);
        end
    end

    // ------------------------------------------------------------------
    // Input side helpers; all are entered and left just after a falling edge.
    // ------------------------------------------------------------------
    function automatic lcd_cmd_t make_item(cmd_t code, logic [7:0] ch, logic [5:0] tcol,
                                           logic [1:0] trow, logic d, logic c, logic b);
        lcd_cmd_t it;
        it.code  = code;
        it.ch    = ch;
        it.tcol  = tcol;
        it.trow  = trow;
        it.disp  = d;
        it.curs  = c;
        it.blink = b;
        return it;
    endfunction

    // Mostly text with newlines mixed in, moves biased toward the wrap edge,
    // and the odd clear or display control. Unused fields stay random.
    function automatic lcd_cmd_t random_item();
        lcd_cmd_t it;
        int       pick;
        pick     = $urandom_range(99);
        it.ch    = 8'($urandom_range(255));
        it.tcol  = 6'($urandom_range(63));
        it.trow  = 2'($urandom_range(3));
        it.disp  = 1'($urandom_range(1));
        it.curs  = 1'($urandom_range(1));
        it.blink = 1'($urandom_range(1));
        if (pick < 68)
        begin
            it.code = CMD_PUT;
            if ($urandom_range(99) < 20)
            begin
                it.ch = NEWLINE_CODE;
            end
        end
        else if (pick < 82)
        begin
            it.code = CMD_MOVE;
            if ($urandom_range(1) == 1)
            begin
                it.tcol = (sb.columns > 1) ? sb.columns - 6'd1 - 6'($urandom_range(1)) : 6'd0;
            end
        end
        else if (pick < 90)
        begin
            it.code = CMD_CLEAR;
        end
        else
        begin
            it.code = CMD_DISPLAY;
        end
        return it;
    endfunction

    task automatic offer_item(input lcd_cmd_t it);
        while (!in_calm_stretch() && $urandom_range(99) < IDLE_PCT)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        command     = it.code;
        char_code   = it.ch;
        target_col  = it.tcol;
        target_row  = it.trow;
        disp_enable = it.disp;
        cursor_on   = it.curs;
        blink_on    = it.blink;
        push        = 1'b1;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        sb.note_item(it);
        @(negedge clk);
    endtask

    // Every item yields nibbles, so an empty owed queue means the block is idle.
    task automatic drain();
        push = 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = value[CFG_DATA_W-1:0];
        sb.set_register(idx, value[CFG_DATA_W-1:0]);
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    // Register settings per random phase; raw values, so 63 checks the clamps,
    // and the zero phase covers every put wrapping and the row always resetting.
    int phase_cols[6]  = '{40, 1, 63, 0, 23, 8};
    int phase_lines[6] = '{4, 1, 63, 0, 3, 7};
    int phase_items[6] = '{60, 50, 55, 15, 60, 55};

    initial
    begin
        lcd_cmd_t directed_q[$];
        int       leftover;
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = REG_COLUMNS;
        cfg_data    = '0;
        push        = 1'b0;
        command     = CMD_PUT;
        char_code   = '0;
        target_col  = '0;
        target_row  = '0;
        disp_enable = 1'b0;
        cursor_on   = 1'b0;
        blink_on    = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part at the reset geometry (16 x 2).
        directed_q.push_back(make_item(CMD_DISPLAY, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0));
        directed_q.push_back(make_item(CMD_DISPLAY, 8'hFF, 6'd63, 2'd3, 1'b1, 1'b1, 1'b1));
        directed_q.push_back(make_item(CMD_CLEAR, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0));
        directed_q.push_back(make_item(CMD_PUT, 8'h00, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0));
        directed_q.push_back(make_item(CMD_PUT, 8'hFF, 6'd63, 2'd3, 1'b1, 1'b1, 1'b1));
        // newline with no pending wrap: no data, forced wrap to the next row
        directed_q.push_back(make_item(CMD_PUT, NEWLINE_CODE, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0));
        // far corner, then a character that wraps both column and row
        directed_q.push_back(make_item(CMD_MOVE, 8'h00, 6'd63, 2'd3, 1'b0, 1'b0, 1'b0));
        directed_q.push_back(make_item(CMD_PUT, 8'h41, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0));
        // newline right after an automatic wrap goes out as a data byte
        directed_q.push_back(make_item(CMD_PUT, NEWLINE_CODE, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0));
        directed_q.push_back(make_item(CMD_MOVE, 8'h00, 6'd15, 2'd0, 1'b0, 1'b0, 1'b0));
        directed_q.push_back(make_item(CMD_PUT, 8'h5A, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0));
        // written newline that itself wraps clears the wrap flag
        directed_q.push_back(make_item(CMD_MOVE, 8'h00, 6'd15, 2'd1, 1'b0, 1'b0, 1'b0));
        directed_q.push_back(make_item(CMD_PUT, NEWLINE_CODE, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0));
        directed_q.push_back(make_item(CMD_PUT, NEWLINE_CODE, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0));
        // rows 2 and 3 add the column count to the address
        directed_q.push_back(make_item(CMD_MOVE, 8'h00, 6'd0, 2'd2, 1'b0, 1'b0, 1'b0));
        directed_q.push_back(make_item(CMD_PUT, 8'h55, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0));
        directed_q.push_back(make_item(CMD_PUT, 8'hAA, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0));
        directed_q.push_back(make_item(CMD_CLEAR, 8'hFF, 6'd63, 2'd3, 1'b1, 1'b1, 1'b1));
        directed_q.push_back(make_item(CMD_DISPLAY, 8'h00, 6'd0, 2'd0, 1'b1, 1'b0, 1'b1));
        directed_q.push_back(make_item(CMD_DISPLAY, 8'h00, 6'd0, 2'd0, 1'b0, 1'b1, 1'b0));
        directed_q.push_back(make_item(CMD_MOVE, 8'h00, 6'd42, 2'd1, 1'b0, 1'b0, 1'b0));
        directed_q.push_back(make_item(CMD_PUT, NEWLINE_CODE, 6'd0, 2'd0, 1'b0, 1'b0, 1'b0));
        foreach (directed_q[i])
        begin
            offer_item(directed_q[i]);
        end

        // Random phases, each under its own geometry; writes only once drained.
        foreach (phase_cols[p])
        begin
            drain();
            write_register(REG_COLUMNS, phase_cols[p]);
            write_register(REG_LINES, phase_lines[p]);
            repeat (phase_items[p])
            begin
                offer_item(random_item());
            end
        end

        drain();
        repeat (8) @(negedge clk);
        leftover = sb.pending();
        if (leftover != 0)
        begin
            $display("%0d expected nibbles never showed up", leftover);
        end
        $display("Run covered %0d commands (put %0d, move %0d, clear %0d, display %0d)",
                 sb.items_in, sb.per_cmd[0], sb.per_cmd[1], sb.per_cmd[2], sb.per_cmd[3]);
        $display("over %0d geometries: %0d nibbles checked, %0d mismatched, %0d unexpected",
                 sb.settings, sb.nibbles_seen, sb.mismatches, sb.strays);
        if (sb.mismatches == 0 && sb.strays == 0 && leftover == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/cltw_pkg.sv
sv/cltw_front.sv
sv/cltw_queue.sv
sv/cltw_back.sv
sv/char_lcd_text_writer_unit.sv
sv/cltw_checker.sv
tb/sv/testbench.sv
